@@ rtl/apt_pkg.sv @@
// Package for the affine point transform: fixed-point widths, register
// indexes and the reset matrix. Used by the top level and its checker.
// No dependencies.
`default_nettype none

package apt_pkg;

   // Q16.16 coordinate and coefficient format
   localparam int COORD_W = 32;
   localparam int FRAC_W  = 16;
   // full product, and the exact sum of three products plus translation
   localparam int PROD_W  = 2 * COORD_W;
   localparam int SUM_W   = PROD_W + 2;
   // rounded value before saturation
   localparam int RND_W   = SUM_W - FRAC_W;

   localparam int NUM_ROWS  = 3;
   localparam int NUM_TERMS = 3;
   localparam int NUM_REGS  = 2 * NUM_ROWS;
   localparam int REG_W     = 2 * COORD_W;
   localparam int CSR_IDX_W = 3;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [SUM_W-1:0]   sum_type;
   typedef logic        [REG_W-1:0]   reg_type;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      XROW_AB = 3'd0,
      XROW_CT = 3'd1,
      YROW_AB = 3'd2,
      YROW_CT = 3'd3,
      ZROW_AB = 3'd4,
      ZROW_CT = 3'd5
   } csr_index_type;

   // half an output LSB, added before truncation for round-to-nearest
   localparam sum_type ROUND_HALF = sum_type'(1) <<< (FRAC_W - 1);

   localparam coord_type COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   localparam reg_type ONE_LO = reg_type'(1) << FRAC_W;
   localparam reg_type ONE_HI = reg_type'(1) << (FRAC_W + COORD_W);

   // reset matrix: identity
   localparam reg_type REG_RESET [NUM_REGS] = '{
      ONE_LO, '0, ONE_HI, '0, '0, ONE_LO
   };

endpackage

`default_nettype wire

@@ rtl/affine_point_transform.sv @@
// Affine point transform, top level: coefficient registers and a three-stage
// multiply / sum / round-saturate pipeline.
// Depends on apt_pkg.
`default_nettype none

// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_stall  req_in_x, req_in_y, req_in_z
// rsp       out        rsp_valid / rsp_stall  rsp_out_x, rsp_out_y, rsp_out_z, rsp_overflow
// csr       in         csr_valid / csr_ready  csr_index, csr_wdata
//
// One point per cycle unless a held result stalls the pipeline; an accepted item
// raises rsp_valid once it has passed the product, sum and output registers.
// Stage 1 holds the nine 32x32 products, stage 2 the exact row sums, stage 3
// the rounded and saturated outputs; the products set the cycle time.
// Reset clears the pipeline valids and loads the identity matrix.
// A stalled result freezes the whole pipeline; req_stall follows it.
// csr writes are always taken and land in the register they name; indexes
// six and seven are dropped.

module affine_point_transform (
   input  wire logic                            clock,
   input  wire logic                            reset,

   input  wire logic                            req_valid,
   output      logic                            req_stall,
   input  wire apt_pkg::coord_type              req_in_x,
   input  wire apt_pkg::coord_type              req_in_y,
   input  wire apt_pkg::coord_type              req_in_z,

   output      logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   output      apt_pkg::coord_type              rsp_out_x,
   output      apt_pkg::coord_type              rsp_out_y,
   output      apt_pkg::coord_type              rsp_out_z,
   output      logic                            rsp_overflow,

   input  wire logic                            csr_valid,
   output      logic                            csr_ready,
   input  wire logic [apt_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire apt_pkg::reg_type                csr_wdata
);

   apt_pkg::reg_type   regs_ff [apt_pkg::NUM_REGS];

   apt_pkg::coord_type coef    [apt_pkg::NUM_ROWS][apt_pkg::NUM_TERMS];
   apt_pkg::coord_type trans   [apt_pkg::NUM_ROWS];
   apt_pkg::coord_type pt      [apt_pkg::NUM_TERMS];

   logic               v1_ff, v2_ff, v3_ff;
   logic               advance;

   apt_pkg::prod_type  prod_ff [apt_pkg::NUM_ROWS][apt_pkg::NUM_TERMS];
   apt_pkg::prod_type  prod_in [apt_pkg::NUM_ROWS][apt_pkg::NUM_TERMS];
   apt_pkg::sum_type   sum_ff  [apt_pkg::NUM_ROWS];
   apt_pkg::sum_type   sum_in  [apt_pkg::NUM_ROWS];
   apt_pkg::coord_type out_ff  [apt_pkg::NUM_ROWS];
   apt_pkg::coord_type out_in  [apt_pkg::NUM_ROWS];
   logic               ovf_ff, ovf_in;

   // register file: always ready, drop indexes past the last register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= apt_pkg::REG_RESET;
      end else if (csr_valid && csr_ready && (csr_index <= apt_pkg::ZROW_CT)) begin
         regs_ff[csr_index] <= csr_wdata;
      end
   end

   // unpack rows: ab holds x and y coefficients, ct holds z and translation
   always_comb begin
      for (int r = 0; r < apt_pkg::NUM_ROWS; r++) begin
         coef[r][0] = regs_ff[2*r][apt_pkg::COORD_W-1:0];
         coef[r][1] = regs_ff[2*r][apt_pkg::REG_W-1:apt_pkg::COORD_W];
         coef[r][2] = regs_ff[2*r+1][apt_pkg::COORD_W-1:0];
         trans[r]   = regs_ff[2*r+1][apt_pkg::REG_W-1:apt_pkg::COORD_W];
      end
   end

   assign pt[0] = req_in_x;
   assign pt[1] = req_in_y;
   assign pt[2] = req_in_z;

   // whole pipeline moves unless the result is held
   assign advance   = !(v3_ff && rsp_stall);
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // stage 1: one signed 32x32 product per coefficient
   always_comb begin
      for (int r = 0; r < apt_pkg::NUM_ROWS; r++) begin
         for (int k = 0; k < apt_pkg::NUM_TERMS; k++) begin
            prod_in[r][k] = apt_pkg::prod_type'(coef[r][k])
                          * apt_pkg::prod_type'(pt[k]);
         end
      end
   end

   // stage 2: exact row sum with translation aligned and half an LSB added
   always_comb begin
      for (int r = 0; r < apt_pkg::NUM_ROWS; r++) begin
         sum_in[r] = apt_pkg::sum_type'(prod_ff[r][0])
                   + apt_pkg::sum_type'(prod_ff[r][1])
                   + apt_pkg::sum_type'(prod_ff[r][2])
                   + (apt_pkg::sum_type'(trans[r]) <<< apt_pkg::FRAC_W)
                   + apt_pkg::ROUND_HALF;
      end
   end

   // stage 3: drop fraction bits, saturate to 32 bits, flag any clamp
   always_comb begin
      logic [apt_pkg::RND_W-1:0] rnd;
      logic                      fits;
      ovf_in = 1'b0;
      for (int r = 0; r < apt_pkg::NUM_ROWS; r++) begin
         rnd  = sum_ff[r][apt_pkg::SUM_W-1:apt_pkg::FRAC_W];
         fits = (&rnd[apt_pkg::RND_W-1:apt_pkg::COORD_W-1]) ||
                !(|rnd[apt_pkg::RND_W-1:apt_pkg::COORD_W-1]);
         if (fits) begin
            out_in[r] = rnd[apt_pkg::COORD_W-1:0];
         end else begin
            out_in[r] = rnd[apt_pkg::RND_W-1] ? apt_pkg::COORD_MIN : apt_pkg::COORD_MAX;
            ovf_in    = 1'b1;
         end
      end
   end

   // payload registers advance with the valids
   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         sum_ff  <= sum_in;
         out_ff  <= out_in;
         ovf_ff  <= ovf_in;
      end
   end

   assign rsp_valid    = v3_ff;
   assign rsp_out_x    = out_ff[0];
   assign rsp_out_y    = out_ff[1];
   assign rsp_out_z    = out_ff[2];
   assign rsp_overflow = ovf_ff;

endmodule

`default_nettype wire

@@ rtl/apt_checker.sv @@
// Port-level checker for the affine point transform, bound to the top level.
// Depends on apt_pkg and affine_point_transform.
`default_nettype none

module apt_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire apt_pkg::coord_type rsp_out_x,
   input wire apt_pkg::coord_type rsp_out_y,
   input wire apt_pkg::coord_type rsp_out_z,
   input wire logic               rsp_overflow
);

   // hold a stalled result and its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_x) &&
         $stable(rsp_out_y) && $stable(rsp_out_z) && $stable(rsp_overflow))
      else $error("stalled result changed");

   // input back-pressure only comes from a held result
   a_stall_src: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req_stall without a held result");

   // an accepted item reaches the output when no stall holds the pipeline
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall ##1 !req_stall ##1 !req_stall |=> rsp_valid)
      else $error("accepted item did not reach the output");

   // a raised overflow shows at least one clamped coordinate
   a_ovf_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |->
         rsp_out_x == apt_pkg::COORD_MAX || rsp_out_x == apt_pkg::COORD_MIN ||
         rsp_out_y == apt_pkg::COORD_MAX || rsp_out_y == apt_pkg::COORD_MIN ||
         rsp_out_z == apt_pkg::COORD_MAX || rsp_out_z == apt_pkg::COORD_MIN)
      else $error("overflow without a saturated coordinate");

endmodule

bind affine_point_transform apt_checker u_apt_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_out_x    (rsp_out_x),
   .rsp_out_y    (rsp_out_y),
   .rsp_out_z    (rsp_out_z),
   .rsp_overflow (rsp_overflow)
);

`default_nettype wire

@@ tb/transform_checker.sv @@
// Checker for the affine point transform: tracks the coefficient registers,
// predicts each transformed point and compares it with the block's results.
// Depends on apt_pkg.

module transform_checker
   import apt_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,

   input  wire logic                    req_valid,
   input  wire logic                    req_stall,
   input  wire coord_type               req_in_x,
   input  wire coord_type               req_in_y,
   input  wire coord_type               req_in_z,

   input  wire logic                    rsp_valid,
   input  wire logic                    rsp_stall,
   input  wire coord_type               rsp_out_x,
   input  wire coord_type               rsp_out_y,
   input  wire coord_type               rsp_out_z,
   input  wire logic                    rsp_overflow,

   input  wire logic                    csr_valid,
   input  wire logic                    csr_ready,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire reg_type                 csr_wdata,

   output int                           mismatch_count,
   output int                           points_in_flight
);

   // wide enough for three full products plus the shifted translation
   typedef logic signed [79:0] wide_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
      logic      overflow;
   } point_type;

   reg_type   matrix [NUM_REGS];
   point_type expected_points [$];
   int        results_seen;

   initial begin
      mismatch_count   = 0;
      points_in_flight = 0;
      results_seen     = 0;
   end

   // Each row: exact dot product with (x, y, z, 1), round half up, saturate.
   function automatic point_type transform_point(coord_type px, coord_type py,
                                                 coord_type pz);
      point_type pt;
      coord_type row_out [NUM_ROWS];
      coord_type ca, cb, cc, tr;
      wide_type  acc;
      pt.overflow = 1'b0;
      for (int r = 0; r < NUM_ROWS; r++) begin
         ca = coord_type'(matrix[2*r][COORD_W-1:0]);
         cb = coord_type'(matrix[2*r][REG_W-1:COORD_W]);
         cc = coord_type'(matrix[2*r+1][COORD_W-1:0]);
         tr = coord_type'(matrix[2*r+1][REG_W-1:COORD_W]);
         acc = wide_type'(ca) * wide_type'(px) + wide_type'(cb) * wide_type'(py)
             + wide_type'(cc) * wide_type'(pz) + (wide_type'(tr) <<< FRAC_W)
             + (wide_type'(1) <<< (FRAC_W - 1));
         acc = acc >>> FRAC_W;
         if (acc > wide_type'(COORD_MAX)) begin
            row_out[r] = COORD_MAX;
            pt.overflow = 1'b1;
         end else if (acc < wide_type'(COORD_MIN)) begin
            row_out[r] = COORD_MIN;
            pt.overflow = 1'b1;
         end else begin
            row_out[r] = coord_type'(acc);
         end
      end
      pt.x = row_out[0];
      pt.y = row_out[1];
      pt.z = row_out[2];
      return pt;
   endfunction

   task automatic report_mismatch(string msg);
      if (mismatch_count < 100)
         $display("MISMATCH @%0t: %s", $time, msg);
      mismatch_count++;
   endtask

   // Sample all channels at the rising edge; results are checked before
   // new items are queued, since a result always belongs to an older item.
   always @(posedge clock) begin
      point_type want;
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++)
            matrix[i] = REG_RESET[i];
         expected_points.delete();
      end else begin
         if (csr_valid && csr_ready && csr_index < NUM_REGS)
            matrix[csr_index] = csr_wdata;

         if (rsp_valid && !rsp_stall) begin
            if (expected_points.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with no point pending",
                                         results_seen));
            end else begin
               want = expected_points.pop_front();
               if (rsp_out_x !== want.x || rsp_out_y !== want.y ||
                   rsp_out_z !== want.z || rsp_overflow !== want.overflow)
                  report_mismatch($sformatf(
                     "result %0d got %h %h %h ovf=%b, want %h %h %h ovf=%b",
                     results_seen, rsp_out_x, rsp_out_y, rsp_out_z, rsp_overflow,
                     want.x, want.y, want.z, want.overflow));
            end
            results_seen++;
         end

         if (req_valid && !req_stall)
            expected_points.push_back(transform_point(req_in_x, req_in_y, req_in_z));
      end
      points_in_flight = expected_points.size();
   end

endmodule

@@ tb/tb_top.sv @@
// Top of the affine point transform testbench: clock, reset, point and
// register stimulus with random idling, watchdog and verdict.
// Depends on apt_pkg, affine_point_transform and transform_checker.

module tb_top;
   import apt_pkg::*;

   localparam int TOTAL_POINTS   = 1050;
   localparam int QUIET_FROM     = 900;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 8;

   localparam coord_type Q_ONE      = 32'sh0001_0000;
   localparam coord_type Q_HALF     = 32'sh0000_8000;
   localparam coord_type Q_TWO      = 32'sh0002_0000;
   localparam coord_type COORD_SPAN = 32'sh0010_0000;
   localparam coord_type COEF_SPAN  = 32'sh0004_0000;
   localparam coord_type SPECIAL_VALUES [8] = '{
      COORD_MAX, COORD_MIN, 32'sh0, -32'sh1, 32'sh1, Q_HALF, Q_ONE, -Q_ONE
   };
   // indexes past the last register; writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] SPARE_INDEX [2] = '{3'd6, 3'd7};

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   coord_type             req_in_x  = '0;
   coord_type             req_in_y  = '0;
   coord_type             req_in_z  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   coord_type             rsp_out_x;
   coord_type             rsp_out_y;
   coord_type             rsp_out_z;
   logic                  rsp_overflow;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   reg_type               csr_wdata = '0;

   int   mismatch_count;
   int   points_in_flight;
   int   points_sent   = 0;
   int   stall_left    = 0;
   int   quiet_cycles  = 0;
   logic req_gaps_on   = 1'b1;
   logic rsp_stalls_on = 1'b1;

   affine_point_transform dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_x     (req_in_x),
      .req_in_y     (req_in_y),
      .req_in_z     (req_in_z),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_x    (rsp_out_x),
      .rsp_out_y    (rsp_out_y),
      .rsp_out_z    (rsp_out_z),
      .rsp_overflow (rsp_overflow),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   transform_checker xform_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_x         (req_in_x),
      .req_in_y         (req_in_y),
      .req_in_z         (req_in_z),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_x        (rsp_out_x),
      .rsp_out_y        (rsp_out_y),
      .rsp_out_z        (rsp_out_z),
      .rsp_overflow     (rsp_overflow),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatch_count   (mismatch_count),
      .points_in_flight (points_in_flight)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Stall the result side in random bursts; none near the end.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if (rsp_stalls_on && points_sent < QUIET_FROM &&
                   $urandom_range(0, 5) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 3);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // End the run when no channel has moved an item for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic reg_type pack_pair(coord_type lo, coord_type hi);
      return {hi, lo};
   endfunction

   // Mix of full-range, near-origin and corner values.
   function automatic coord_type rand_coord();
      case ($urandom_range(0, 7))
         0, 1, 2: return coord_type'($urandom);
         3, 4, 5: return coord_type'($urandom_range(0, 2 * COORD_SPAN)) - COORD_SPAN;
         default: return SPECIAL_VALUES[$urandom_range(0, 7)];
      endcase
   endfunction

   // Coefficients lean toward small magnitudes so that not every sum saturates.
   function automatic coord_type rand_coef();
      case ($urandom_range(0, 7))
         0, 1:    return coord_type'($urandom);
         2, 3, 4, 5:
                  return coord_type'($urandom_range(0, 2 * COEF_SPAN)) - COEF_SPAN;
         default: return SPECIAL_VALUES[$urandom_range(0, 7)];
      endcase
   endfunction

   // Present one point and hold it until taken; noise on the payload in gaps.
   task automatic send_point(coord_type px, coord_type py, coord_type pz);
      if (req_gaps_on && points_sent < QUIET_FROM && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         req_in_x  <= coord_type'($urandom);
         req_in_y  <= coord_type'($urandom);
         req_in_z  <= coord_type'($urandom);
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_in_x  <= px;
      req_in_y  <= py;
      req_in_z  <= pz;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      points_sent++;
      @(negedge clock);
   endtask

   // Leaves csr_valid high so back-to-back writes need no drop in between.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, reg_type data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Write all six registers from a random starting one, with stray writes
   // to the unused indexes mixed in.
   task automatic load_matrix(input reg_type m [NUM_REGS], input int spare_pct);
      int first;
      int idx;
      first = $urandom_range(0, NUM_REGS - 1);
      for (int k = 0; k < NUM_REGS; k++) begin
         idx = (first + k) % NUM_REGS;
         write_reg(csr_index_type'(idx), m[idx]);
         if ($urandom_range(0, 99) < spare_pct)
            write_reg(SPARE_INDEX[$urandom_range(0, 1)], {$urandom, $urandom});
      end
      csr_valid <= 1'b0;
   endtask

   // Drop valid and wait until the pipeline has drained.
   task automatic settle();
      req_valid <= 1'b0;
      while (points_in_flight != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      reg_type    m [NUM_REGS];
      int         burst;
      logic [1:0] mode;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // identity after reset: points pass through unchanged
      send_point(COORD_MAX, COORD_MIN, 32'sh0);
      send_point(COORD_MIN, COORD_MAX, -32'sh1);
      send_point(32'sh1, -32'sh1, Q_ONE);
      send_point(32'sh5555_5555, coord_type'(32'hAAAA_AAAA), 32'sh7FFF_0000);

      // half-LSB ties in x, doubling into saturation in y, negation plus one in z
      settle();
      m[XROW_AB] = pack_pair(Q_HALF, 32'sh0);
      m[XROW_CT] = pack_pair(32'sh0, 32'sh0);
      m[YROW_AB] = pack_pair(32'sh0, Q_TWO);
      m[YROW_CT] = pack_pair(32'sh0, 32'sh0);
      m[ZROW_AB] = pack_pair(32'sh0, 32'sh0);
      m[ZROW_CT] = pack_pair(-Q_ONE, Q_ONE);
      load_matrix(m, 100);
      send_point(32'sh1, COORD_MAX, 32'sh0);
      send_point(-32'sh1, 32'sh0, COORD_MIN);
      send_point(32'sh3, COORD_MIN, COORD_MAX);
      send_point(-32'sh3, 32'sh1, 32'sh0);

      // most negative coefficients everywhere
      settle();
      m = '{default: pack_pair(COORD_MIN, COORD_MIN)};
      load_matrix(m, 0);
      send_point(COORD_MIN, COORD_MIN, COORD_MIN);
      send_point(COORD_MAX, COORD_MAX, COORD_MAX);
      send_point(32'sh0, 32'sh0, 32'sh0);
      send_point(32'sh1, -32'sh1, 32'sh1);

      // most positive coefficients everywhere
      settle();
      m = '{default: pack_pair(COORD_MAX, COORD_MAX)};
      load_matrix(m, 0);
      send_point(COORD_MAX, COORD_MAX, COORD_MAX);
      send_point(COORD_MIN, COORD_MIN, COORD_MIN);
      send_point(COORD_MIN, COORD_MAX, 32'sh0);

      // all ones: every coefficient and translation is minus one LSB
      settle();
      m = '{default: '1};
      load_matrix(m, 0);
      send_point(COORD_MAX, COORD_MIN, 32'sh1);
      send_point(32'sh0, 32'sh0, 32'sh0);

      // zero matrix
      settle();
      m = '{default: '0};
      load_matrix(m, 0);
      send_point(COORD_MAX, COORD_MIN, -32'sh1);

      // random matrices, each with a random run of points and idling mode
      while (points_sent < TOTAL_POINTS) begin
         settle();
         for (int k = 0; k < NUM_REGS; k++)
            m[k] = pack_pair(rand_coef(), rand_coef());
         load_matrix(m, 20);
         mode = 2'($urandom_range(0, 3));
         req_gaps_on   = mode[0];
         rsp_stalls_on = mode[1];
         burst = $urandom_range(20, 120);
         for (int k = 0; k < burst && points_sent < TOTAL_POINTS; k++)
            send_point(rand_coord(), rand_coord(), rand_coord());
      end

      settle();
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
